[design/i2rd_pkg.sv]
// Shared types, constants and the digit alphabet for the radix digit converter.
// Used by i2rd_ctrl, i2rd_datapath and integer_to_radix_digits; depends on nothing.
package i2rd_pkg;

   localparam int DIGIT_SLOTS_DEFAULT = 32;
   localparam int VALUE_WIDTH_DEFAULT = 31;
   localparam int RUN_LIMIT           = 31;

   localparam int RADIX_WIDTH = 9;
   localparam int CHAR_WIDTH  = 7;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET     = 9'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN       = 9'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX_DIGIT = 9'd64;
   localparam logic [RADIX_WIDTH-1:0] RADIX_BYTES     = 9'd256;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 7'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER = 7'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER = 7'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 7'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH = 7'h2F;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DOT   = 7'h2E;

   typedef enum logic [1:0] {
      MODE_DIV,
      MODE_POW2,
      MODE_BYTE,
      MODE_BAD
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_POW2,
      ST_DIV,
      ST_DIV_PUSH,
      ST_BYTE_SPLIT,
      ST_BYTE_DIGIT,
      ST_BYTE_DOT,
      ST_EMIT_START,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic pow2_push;
      logic div_start;
      logic div_step;
      logic div_push;
      logic byte_split;
      logic byte_push;
      logic dot_push;
      logic out_load;
      logic bad_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     pow2_last;
      logic     div_last;
      logic     rem_zero;
      logic     byte_last;
      logic     out_final;
   } status_type;

   // Alphabet 0-9A-Za-z+/
   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [5:0] d);
      logic [CHAR_WIDTH-1:0] c;
      priority if (d < 6'd10) begin
         c = CHAR_ZERO + {1'b0, d};
      end else if (d < 6'd36) begin
         c = CHAR_UPPER + {1'b0, d} - 7'd10;
      end else if (d < 6'd62) begin
         c = CHAR_LOWER + {1'b0, d} - 7'd36;
      end else if (d == 6'd62) begin
         c = CHAR_PLUS;
      end else begin
         c = CHAR_SLASH;
      end
      return c;
   endfunction

endpackage

[design/i2rd_datapath.sv]
// Datapath of the radix digit converter: radix register, remainder/divider unit,
// byte splitter, digit store and result word registers. Depends on i2rd_pkg.
module i2rd_datapath
   import i2rd_pkg::*;
#(
   parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [RADIX_WIDTH-1:0] csr_radix,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [CHAR_WIDTH-1:0]  rsp_character,
   output logic                   rsp_final_char,
   output logic                   rsp_bad_radix
);

   localparam int RUN_CAP = (DIGIT_SLOTS < RUN_LIMIT) ? DIGIT_SLOTS : RUN_LIMIT;
   localparam int CW      = $clog2(RUN_CAP + 1);
   localparam int AW      = $clog2(DIGIT_SLOTS);
   localparam int SW      = $clog2(VALUE_WIDTH);

   logic [RADIX_WIDTH-1:0] radix_ff;
   mode_type               mode_ff;
   mode_type               mode_in;
   logic [2:0]             shift_ff;
   logic [2:0]             shift_in;
   logic [5:0]             mask_ff;
   logic [6:0]             divisor_ff;
   logic [VALUE_WIDTH-1:0] rem_ff;
   logic [VALUE_WIDTH-1:0] rem_in;
   logic [5:0]             part_ff;
   logic [5:0]             part_in;
   logic [SW-1:0]          step_ff;
   logic [SW-1:0]          step_in;
   logic [7:0]             byte_ff;
   logic [7:0]             byte_in;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [CHAR_WIDTH-1:0]  store [DIGIT_SLOTS];
   logic [CHAR_WIDTH-1:0]  char_ff;
   logic                   final_ff;
   logic                   bad_ff;

   logic                   radix_bad;
   logic                   radix_pow2;
   logic [VALUE_WIDTH-1:0] rem_shift;
   logic [6:0]             trial;
   logic                   trial_ge;
   logic [6:0]             trial_diff;
   logic [15:0]            byte_prod;
   logic [4:0]             byte_quot;
   logic [7:0]             byte_digit;
   logic                   push_en;
   logic                   store_room;
   logic [CHAR_WIDTH-1:0]  push_char;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;

   assign csr_ready = 1'b1;

   // Radix decode, taken into mode registers when a word is accepted
   assign radix_bad  = (radix_ff < RADIX_MIN)
                    || ((radix_ff > RADIX_MAX_DIGIT) && (radix_ff != RADIX_BYTES));
   assign radix_pow2 = (radix_ff & (radix_ff - 9'd1)) == '0;

   always_comb begin
      priority if (radix_bad) begin
         mode_in = MODE_BAD;
      end else if (radix_ff == RADIX_BYTES) begin
         mode_in = MODE_BYTE;
      end else if (radix_pow2) begin
         mode_in = MODE_POW2;
      end else begin
         mode_in = MODE_DIV;
      end
   end

   always_comb begin
      shift_in = '0;
      for (int i = 1; i <= 6; i++) begin
         if (radix_ff[i]) begin
            shift_in = 3'(i);
         end
      end
   end

   // Power-of-two bases: mask and shift
   assign rem_shift = rem_ff >> shift_ff;

   // Restoring division, one quotient bit per cycle
   assign trial      = {part_ff, rem_ff[VALUE_WIDTH-1]};
   assign trial_ge   = trial >= divisor_ff;
   assign trial_diff = trial - divisor_ff;

   // Byte to decimal: b / 10 == (b * 205) >> 11 for every 8-bit b
   assign byte_prod  = byte_ff * 16'd205;
   assign byte_quot  = byte_prod[15:11];
   assign byte_digit = byte_ff - ({byte_quot, 3'b000} + {2'b00, byte_quot, 1'b0});

   assign push_en    = cmd.pow2_push | cmd.div_push | cmd.byte_push | cmd.dot_push;
   assign store_room = count_ff < CW'(RUN_CAP);
   assign wr_addr    = AW'(count_ff);
   assign rd_addr    = AW'(count_ff - CW'(1));

   always_comb begin
      priority if (cmd.pow2_push) begin
         push_char = digit_char(rem_ff[5:0] & mask_ff);
      end else if (cmd.div_push) begin
         push_char = digit_char(part_ff);
      end else if (cmd.byte_push) begin
         push_char = digit_char({2'b00, byte_digit[3:0]});
      end else begin
         push_char = CHAR_DOT;
      end
   end

   always_comb begin
      rem_in = rem_ff;
      priority if (cmd.load) begin
         rem_in = req_value;
      end else if (cmd.pow2_push) begin
         rem_in = rem_shift;
      end else if (cmd.div_step) begin
         rem_in = {rem_ff[VALUE_WIDTH-2:0], trial_ge};
      end else if (cmd.byte_split) begin
         rem_in = rem_ff >> 8;
      end
   end

   always_comb begin
      count_in = count_ff;
      priority if (cmd.load) begin
         count_in = '0;
      end else if (push_en && store_room) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.out_load) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      part_in = part_ff;
      step_in = step_ff;
      priority if (cmd.div_start) begin
         part_in = '0;
         step_in = '0;
      end else if (cmd.div_step) begin
         part_in = trial_ge ? trial_diff[5:0] : trial[5:0];
         step_in = step_ff + SW'(1);
      end
   end

   always_comb begin
      byte_in = byte_ff;
      priority if (cmd.byte_split) begin
         byte_in = rem_ff[7:0];
      end else if (cmd.byte_push) begin
         byte_in = {3'b000, byte_quot};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         count_ff <= '0;
         rem_ff   <= '0;
      end else begin
         if (csr_valid) begin
            radix_ff <= csr_radix;
         end
         count_ff <= count_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= mode_in;
         shift_ff   <= shift_in;
         mask_ff    <= 6'(radix_ff[5:0] - 6'd1);
         divisor_ff <= radix_ff[6:0];
      end
      part_ff <= part_in;
      step_ff <= step_in;
      byte_ff <= byte_in;
   end

   // Digit store: written least significant first, read back in reverse
   always_ff @(posedge clock) begin
      if (push_en && store_room) begin
         store[wr_addr] <= push_char;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         char_ff  <= store[rd_addr];
         final_ff <= count_ff == CW'(1);
         bad_ff   <= 1'b0;
      end else if (cmd.bad_load) begin
         char_ff  <= CHAR_NUL;
         final_ff <= 1'b1;
         bad_ff   <= 1'b1;
      end
   end

   assign rsp_character  = char_ff;
   assign rsp_final_char = final_ff;
   assign rsp_bad_radix  = bad_ff;

   assign status.mode      = mode_ff;
   assign status.pow2_last = rem_shift == '0;
   assign status.div_last  = step_ff == SW'(VALUE_WIDTH - 1);
   assign status.rem_zero  = rem_ff == '0;
   assign status.byte_last = byte_quot == '0;
   assign status.out_final = final_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RUN_CAP))
      else $error("digit count exceeds run cap");

   a_part_below: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> ({1'b0, part_ff} < divisor_ff))
      else $error("partial remainder not below divisor");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (count_ff != '0))
      else $error("digit store read while empty");

endmodule

[design/i2rd_ctrl.sv]
// Controller state machine of the radix digit converter: sequences digit
// generation and character output. Depends on i2rd_pkg.
module i2rd_ctrl
   import i2rd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.mode)
               MODE_BAD: begin
                  cmd.bad_load = 1'b1;
                  state_in     = ST_EMIT;
               end
               MODE_BYTE: state_in = ST_BYTE_SPLIT;
               MODE_POW2: state_in = ST_POW2;
               MODE_DIV: begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_POW2: begin
            cmd.pow2_push = 1'b1;
            if (status.pow2_last) begin
               state_in = ST_EMIT_START;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DIV_PUSH;
            end
         end
         ST_DIV_PUSH: begin
            cmd.div_push = 1'b1;
            if (status.rem_zero) begin
               state_in = ST_EMIT_START;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_BYTE_SPLIT: begin
            cmd.byte_split = 1'b1;
            state_in       = ST_BYTE_DIGIT;
         end
         ST_BYTE_DIGIT: begin
            cmd.byte_push = 1'b1;
            if (status.byte_last) begin
               state_in = status.rem_zero ? ST_EMIT_START : ST_BYTE_DOT;
            end
         end
         ST_BYTE_DOT: begin
            cmd.dot_push = 1'b1;
            state_in     = ST_BYTE_SPLIT;
         end
         ST_EMIT_START: begin
            cmd.out_load = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // advance only when the held word is taken
            if (!rsp_stall) begin
               if (status.out_final) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.out_load = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_EMIT;

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DISPATCH))
      else $error("accepted word did not start dispatch");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && status.out_final) |=> (state_ff == ST_IDLE))
      else $error("final character taken but run continues");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response word dropped");

endmodule

[design/integer_to_radix_digits.sv]
// Top level of the radix digit converter: joins controller and datapath.
// Depends on i2rd_pkg, i2rd_ctrl and i2rd_datapath.
//
// Converts one non-negative value per request word into ASCII digit characters, most
// significant first, one response word per character, with rsp_final_char on the last.
// The base comes from csr_radix (reset 10): 2..64 use 0-9A-Za-z+/, 256 gives the bytes
// in dotted decimal, any other base gives a single word with rsp_bad_radix set and
// character 0. One value is in flight at a time. Non-power-of-two bases run a one-bit-
// per-cycle divider with a digit push after each quotient. Power-of-two bases take each
// digit by mask and shift; base 256 splits off each byte and pushes its decimal digits,
// with a dot between bytes. Accept and dispatch states come first and a readout-start
// state follows; characters then leave the digit store at one per cycle while not stalled.
// Write csr_radix only while no value is in flight.
module integer_to_radix_digits
   import i2rd_pkg::*;
#(
   parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [RADIX_WIDTH-1:0] csr_radix,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAR_WIDTH-1:0]  rsp_character,
   output logic                   rsp_final_char,
   output logic                   rsp_bad_radix
);

   cmd_type    cmd;
   status_type status;

   i2rd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   i2rd_datapath #(
      .DIGIT_SLOTS (DIGIT_SLOTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_radix      (csr_radix),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_character  (rsp_character),
      .rsp_final_char (rsp_final_char),
      .rsp_bad_radix  (rsp_bad_radix)
   );

endmodule

[verif/tb_integer_to_radix_digits.sv]
// Self-checking testbench for integer_to_radix_digits: directed and random values over
// many radix settings, checked word by word against an in-bench digit predictor.
// Depends on i2rd_pkg and the integer_to_radix_digits RTL.
module tb_integer_to_radix_digits;
   import i2rd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW = VALUE_WIDTH_DEFAULT;
   localparam string DIGIT_SET =
      "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+/";

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  final_char;
      logic                  bad_radix;
   } digit_word_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [RADIX_WIDTH-1:0] csr_radix = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [VW-1:0]          req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHAR_WIDTH-1:0]  rsp_character;
   logic                   rsp_final_char;
   logic                   rsp_bad_radix;

   digit_word_type         pending_digits[$];
   logic [RADIX_WIDTH-1:0] radix_setting = RADIX_RESET;
   int                     gap_pct = 0;
   int                     stall_pct = 0;
   int                     stall_hold = 0;
   int                     error_count = 0;
   int                     values_sent = 0;
   int                     words_checked = 0;
   int                     radix_writes = 0;

   integer_to_radix_digits DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_radix      (csr_radix),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_final_char (rsp_final_char),
      .rsp_bad_radix  (rsp_bad_radix)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      if (error_count < 40) begin
         $display("[%0t] MISMATCH: %s", $time, msg);
      end
      error_count++;
   endtask

   // Expected words for one value under the current radix, most significant first.
   function automatic void predict_digits(input logic [VW-1:0] value);
      logic [CHAR_WIDTH-1:0] lsd_first[$];
      logic [VW-1:0]         rest;
      int unsigned           base;
      int unsigned           byte_val;
      int                    k;
      digit_word_type        w;
      base = radix_setting;
      if (base < 2 || (base > 64 && base != 256)) begin
         w.character  = CHAR_NUL;
         w.final_char = 1'b1;
         w.bad_radix  = 1'b1;
         pending_digits.push_back(w);
         return;
      end
      rest = value;
      if (base == 256) begin
         do begin
            byte_val = rest[7:0];
            rest     = rest >> 8;
            do begin
               lsd_first.push_back(CHAR_WIDTH'(DIGIT_SET[byte_val % 10]));
               byte_val = byte_val / 10;
            end while (byte_val != 0);
            if (rest != 0) begin
               lsd_first.push_back(CHAR_DOT);
            end
         end while (rest != 0);
      end else begin
         do begin
            lsd_first.push_back(CHAR_WIDTH'(DIGIT_SET[rest % base]));
            rest = VW'(rest / base);
         end while (rest != 0);
      end
      for (k = lsd_first.size() - 1; k >= 0; k--) begin
         w.character  = lsd_first[k];
         w.final_char = (k == 0);
         w.bad_radix  = 1'b0;
         pending_digits.push_back(w);
      end
   endfunction

   // Response side: random stall, now and then a long one.
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall  <= 1'b1;
         stall_hold <= stall_hold - 1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         if ($urandom_range(0, 19) == 0) begin
            stall_hold <= $urandom_range(10, 40);
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      digit_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (pending_digits.size() == 0) begin
            flag_mismatch($sformatf("unexpected word char=%h final=%b bad=%b",
                                    rsp_character, rsp_final_char, rsp_bad_radix));
         end else begin
            want = pending_digits.pop_front();
            if (rsp_character !== want.character) begin
               flag_mismatch($sformatf("character got %h want %h (radix %0d)",
                                       rsp_character, want.character, radix_setting));
            end
            if (rsp_final_char !== want.final_char) begin
               flag_mismatch($sformatf("final_char got %b want %b (radix %0d)",
                                       rsp_final_char, want.final_char, radix_setting));
            end
            if (rsp_bad_radix !== want.bad_radix) begin
               flag_mismatch($sformatf("bad_radix got %b want %b (radix %0d)",
                                       rsp_bad_radix, want.bad_radix, radix_setting));
            end
         end
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 99) >= gap_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Keep valid high across back-to-back words; drop it only for a gap.
   task automatic send_value(input logic [VW-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      predict_digits(value);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      values_sent++;
   endtask

   task automatic wait_drained();
      int cycles;
      cycles = 0;
      req_valid <= 1'b0;
      while (pending_digits.size() != 0 && cycles < 20000) begin
         @(posedge clock);
         cycles++;
      end
      if (pending_digits.size() != 0) begin
         flag_mismatch($sformatf("%0d words never arrived", pending_digits.size()));
         pending_digits.delete();
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_WIDTH-1:0] base);
      wait_drained();
      csr_valid <= 1'b1;
      csr_radix <= base;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      radix_setting  = base;
      radix_writes++;
   endtask

   function automatic logic [RADIX_WIDTH-1:0] pick_radix();
      case ($urandom_range(0, 9))
         0: return RADIX_BYTES;
         1: return RADIX_WIDTH'(1 << $urandom_range(1, 6));
         2: begin
            case ($urandom_range(0, 2))
               0: return RADIX_WIDTH'($urandom_range(0, 1));
               1: return RADIX_WIDTH'($urandom_range(65, 255));
               default: return RADIX_WIDTH'($urandom_range(257, 511));
            endcase
         end
         default: return RADIX_WIDTH'($urandom_range(2, 64));
      endcase
   endfunction

   function automatic logic [VW-1:0] pick_value();
      logic [31:0] mask;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return VW'($urandom_range(0, 300));
         default: begin
            mask = (32'h1 << $urandom_range(1, VW)) - 32'h1;
            return VW'($urandom & mask);
         end
      endcase
   endfunction

   task automatic pick_pressure();
      case ($urandom_range(0, 3))
         0: gap_pct = 0;
         1: gap_pct = 10;
         2: gap_pct = 30;
         default: gap_pct = 60;
      endcase
      case ($urandom_range(0, 3))
         0: stall_pct = 0;
         1: stall_pct = 10;
         2: stall_pct = 30;
         default: stall_pct = 60;
      endcase
   endtask

   // Radix left at its reset value of ten.
   task automatic test_default_decimal();
      gap_pct   = 30;
      stall_pct = 30;
      send_value('0);
      send_value(VW'(1));
      send_value(VW'(9));
      send_value(VW'(10));
      send_value('1);
   endtask

   // Dotted bytes, zero bytes printed as a single digit.
   task automatic test_byte_form();
      write_radix(RADIX_BYTES);
      send_value('0);
      send_value(VW'(255));
      send_value(VW'(256));
      send_value(VW'(32'h7F00FF00));
      send_value('1);
   endtask

   task automatic test_pow2_bases();
      write_radix(RADIX_MIN);
      send_value('1);
      send_value(VW'(1));
      write_radix(RADIX_MAX_DIGIT);
      send_value(VW'(63));
      send_value(VW'(64));
      send_value('1);
   endtask

   task automatic test_division_bases();
      write_radix(9'd3);
      send_value('1);
      write_radix(9'd36);
      send_value(VW'(35));
      write_radix(9'd63);
      send_value(VW'(62));
   endtask

   task automatic test_bad_radix();
      write_radix(9'd0);
      send_value(VW'(1));
      write_radix(9'd1);
      send_value('0);
      write_radix(9'd65);
      send_value(pick_value());
      write_radix(9'd255);
      send_value(pick_value());
      write_radix(9'd257);
      send_value(pick_value());
      write_radix(9'd511);
      send_value('1);
   endtask

   task automatic test_random_mix();
      int phase;
      int n;
      for (phase = 0; phase < 24; phase++) begin
         write_radix(pick_radix());
         pick_pressure();
         for (n = 0; n < 10; n++) begin
            send_value(pick_value());
         end
      end
   endtask

   // No gaps and no stalls at all.
   task automatic test_back_to_back();
      int phase;
      int n;
      for (phase = 0; phase < 2; phase++) begin
         write_radix(phase == 0 ? RADIX_BYTES : RADIX_WIDTH'($urandom_range(2, 64)));
         gap_pct   = 0;
         stall_pct = 0;
         for (n = 0; n < 25; n++) begin
            send_value(pick_value());
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_decimal();
      test_byte_form();
      test_pow2_bases();
      test_division_bases();
      test_bad_radix();
      test_random_mix();
      test_back_to_back();
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Converted %0d values into %0d checked words across %0d radix writes,",
               values_sent, words_checked, radix_writes);
      $display("including bases 2, 64, 256, illegal bases and random pressure on both sides.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
